// ===== src/sat_pkg.sv =====
// Shared types and constants for the sorted address table.
// Holds the table size and widths, empty-slot marker, operation and status codes, and the command struct.
// No dependencies.
`default_nettype none

package sat_pkg;

	// Table geometry
	localparam int ENTRIES = 16;
	localparam int ADDR_W  = 48;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 5;
	localparam int IDX_W   = 4;

	// Empty slot marker: all ones, so no address sorts after it
	localparam logic [ADDR_W-1:0] EMPTY_SLOT = {ADDR_W{1'b1}};

	// Operation codes; code 3 is unused
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_EVICTED   = 3'd2,
		ST_FULL      = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_NOT_FOUND = 3'd5,
		ST_RESTARTED = 3'd6
	} status_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the incoming word
		logic exec;    // apply the operation to the table
		logic report;  // count entries and locate own address
	} sat_cmd_t;

endpackage

`default_nettype wire

// ===== src/sat_ctrl.sv =====
// Controller for the sorted address table: sequences load, execute, report.
// Depends on sat_pkg.
`default_nettype none

module sat_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output sat_pkg::sat_cmd_t   cmd
);
	import sat_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPORT
	} state_t;

	state_t state_q;
	logic   done_q;

	// Commands follow the state directly
	always_comb begin
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.exec   = (state_q == S_EXEC);
		cmd.report = (state_q == S_REPORT);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/sat_dp.sv =====
// Datapath for the sorted address table: entry registers, parallel compare
// and shift, own address register and result registers. Depends on sat_pkg.
`default_nettype none

module sat_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sat_pkg::sat_cmd_t             cmd,
	input  wire logic [1:0]                    operation,
	input  wire logic [sat_pkg::ADDR_W-1:0]    address,
	input  wire logic                          own_address_we,
	input  wire logic [sat_pkg::ADDR_W-1:0]    own_address,
	output logic [sat_pkg::STAT_W-1:0]         status,
	output logic [sat_pkg::CNT_W-1:0]          entry_count,
	output logic [sat_pkg::IDX_W-1:0]          own_index
);
	import sat_pkg::*;

	logic [ADDR_W-1:0] table_q [ENTRIES];
	logic [ADDR_W-1:0] own_q;
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [STAT_W-1:0] op_status_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  index_q;

	logic [ENTRIES-1:0] eq, lt, hit, pre_hit, first_hit, rm_shift;
	logic [ADDR_W-1:0]  tbl_nxt [ENTRIES];
	logic [STAT_W-1:0]  stat_nxt;
	logic [CNT_W-1:0]   cnt_c;
	logic [IDX_W-1:0]   idx_c;
	logic               open_c;

	// Parallel compare of the held word against every entry
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			eq[i]  = (addr_q == table_q[i]);
			lt[i]  = (addr_q < table_q[i]);
			hit[i] = eq[i] | lt[i];
		end
		pre_hit[0]  = 1'b0;
		rm_shift[0] = eq[0];
		for (int i = 1; i < ENTRIES; i++) begin
			pre_hit[i]  = pre_hit[i-1] | hit[i-1];
			rm_shift[i] = rm_shift[i-1] | eq[i];
		end
		first_hit = hit & ~pre_hit;
	end

	// Next table contents and status
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) tbl_nxt[j] = table_q[j];
		stat_nxt = ST_NOT_FOUND;
		unique case (op_q)
			OP_INSERT: begin
				if (!(|hit)) begin
					stat_nxt = ST_FULL;
				end else if (|(first_hit & eq)) begin
					stat_nxt = ST_PRESENT;
				end else begin
					stat_nxt = (table_q[ENTRIES-1] != EMPTY_SLOT) ? ST_EVICTED : ST_INSERTED;
					for (int j = 1; j < ENTRIES; j++) begin
						if (pre_hit[j]) tbl_nxt[j] = table_q[j-1];
					end
					for (int j = 0; j < ENTRIES; j++) begin
						if (first_hit[j]) tbl_nxt[j] = addr_q;
					end
				end
			end
			OP_REMOVE: begin
				if (|eq) begin
					stat_nxt = ST_REMOVED;
					for (int j = 0; j < ENTRIES - 1; j++) begin
						if (rm_shift[j]) tbl_nxt[j] = table_q[j+1];
					end
					tbl_nxt[ENTRIES-1] = EMPTY_SLOT;
				end
			end
			OP_RESTART: begin
				stat_nxt = ST_RESTARTED;
				for (int j = 1; j < ENTRIES; j++) tbl_nxt[j] = EMPTY_SLOT;
				tbl_nxt[0] = own_q;
			end
			default: begin
				stat_nxt = ST_NOT_FOUND;
			end
		endcase
	end

	// Occupied count and last index holding own address
	always_comb begin
		cnt_c  = '0;
		idx_c  = '0;
		open_c = 1'b1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (open_c && (table_q[i] != EMPTY_SLOT)) begin
				cnt_c = CNT_W'(i + 1);
				if (table_q[i] == own_q) idx_c = IDX_W'(i);
			end else begin
				open_c = 1'b0;
			end
		end
	end

	// Entry and own address registers; entries reset to empty, own address to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) table_q[i] <= EMPTY_SLOT;
			own_q <= '0;
		end else begin
			if (cmd.exec) begin
				for (int i = 0; i < ENTRIES; i++) table_q[i] <= tbl_nxt[i];
			end
			if (own_address_we) own_q <= own_address;
		end
	end

	// Held word, status and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			addr_q <= address;
		end
		if (cmd.exec) op_status_q <= stat_nxt;
		if (cmd.report) begin
			status_q <= op_status_q;
			count_q  <= cnt_c;
			index_q  <= idx_c;
		end
	end

	assign status      = status_q;
	assign entry_count = count_q;
	assign own_index   = index_q;

endmodule

`default_nettype wire

// ===== src/sorted_address_table.sv =====
// Top level of the sorted address table: joins controller and datapath.
// Depends on sat_pkg, sat_ctrl and sat_dp.
//
//  channel   handshake          payload
//  command   start / busy       operation, address
//  result    done (one cycle)   status, entry_count, own_index
//  config    own_address_we     own_address
//
// Each word passes through capture, one table update (parallel compare and
// shift over all entries), then count and locate; done follows, and a new
// start can be taken in the cycle done is high. Reset empties every slot and
// clears own_address. The receiver cannot stall; results are never held.
`default_nettype none

module sorted_address_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    operation,
	input  wire logic [sat_pkg::ADDR_W-1:0]    address,
	input  wire logic                          own_address_we,
	input  wire logic [sat_pkg::ADDR_W-1:0]    own_address,
	output logic                               done,
	output logic [sat_pkg::STAT_W-1:0]         status,
	output logic [sat_pkg::CNT_W-1:0]          entry_count,
	output logic [sat_pkg::IDX_W-1:0]          own_index
);
	import sat_pkg::*;

	sat_cmd_t cmd;

	sat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	sat_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.operation      (operation),
		.address        (address),
		.own_address_we (own_address_we),
		.own_address    (own_address),
		.status         (status),
		.entry_count    (entry_count),
		.own_index      (own_index)
	);

endmodule

`default_nettype wire

// ===== verif/sorted_address_table_tb.sv =====
// Self-checking testbench for the sorted address table.
// A scripted opening and then random traffic with checks against an in-bench model.
// Depends on sat_pkg and sorted_address_table.
`timescale 1ns / 1ps

module sorted_address_table_tb;
	import sat_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 7;
	localparam int WORDS_PER_PHASE = 90;
	localparam int POOL_MAX = 40;
	localparam int SCRIPT_LEN = 21;

	// One expected report: status, occupied count, own address position
	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [CNT_W-1:0]  cnt;
		logic [IDX_W-1:0]  idx;
	} report_t;

	// Opening script row: an own address write or a word (repeated, 0x10 apart)
	typedef struct packed {
		logic              own_wr;
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [4:0]        rep;
		logic              fixed;
		report_t           want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] operation;
	logic [ADDR_W-1:0] address;
	logic own_address_we;
	logic [ADDR_W-1:0] own_address;
	logic done;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0] entry_count;
	logic [IDX_W-1:0] own_index;

	// Shadow copy of the table and own address
	logic [ADDR_W-1:0] shadow_table [ENTRIES];
	logic [ADDR_W-1:0] shadow_own;

	report_t pending_reports [$];
	script_row_t script [SCRIPT_LEN];
	logic [ADDR_W-1:0] addr_pool [POOL_MAX];
	int pool_n;

	int cycles;
	int mismatches;
	int reports_checked;
	int words_sent;
	int own_writes;
	int status_seen [8];

	sorted_address_table DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.address        (address),
		.own_address_we (own_address_we),
		.own_address    (own_address),
		.done           (done),
		.status         (status),
		.entry_count    (entry_count),
		.own_index      (own_index)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d reports outstanding",
				cycles, pending_reports.size());
			$display("FAIL");
			$finish;
		end
	end

	// Apply one word to the shadow table and work out its report
	function automatic report_t table_update(input logic [1:0] op, input logic [ADDR_W-1:0] a);
		report_t r;
		int pos;
		int n;
		int where;
		bit stop;
		pos = -1;
		r.st = ST_NOT_FOUND;
		case (op)
			OP_INSERT: begin
				r.st = ST_FULL;
				for (int i = 0; i < ENTRIES; i++) begin
					if (a == shadow_table[i]) begin
						r.st = ST_PRESENT;
						break;
					end
					if (a < shadow_table[i]) begin
						pos = i;
						break;
					end
				end
				if (pos >= 0) begin
					if (shadow_table[ENTRIES-1] != EMPTY_SLOT)
						r.st = ST_EVICTED;
					else
						r.st = ST_INSERTED;
					for (int j = ENTRIES - 1; j > pos; j--)
						shadow_table[j] = shadow_table[j-1];
					shadow_table[pos] = a;
				end
			end
			OP_REMOVE: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (a == shadow_table[i]) begin
						pos = i;
						break;
					end
				end
				if (pos >= 0) begin
					for (int j = pos; j + 1 < ENTRIES; j++)
						shadow_table[j] = shadow_table[j+1];
					shadow_table[ENTRIES-1] = EMPTY_SLOT;
					r.st = ST_REMOVED;
				end
			end
			OP_RESTART: begin
				for (int i = 0; i < ENTRIES; i++)
					shadow_table[i] = EMPTY_SLOT;
				shadow_table[0] = shadow_own;
				r.st = ST_RESTARTED;
			end
			default: r.st = ST_NOT_FOUND;
		endcase
		// count up to the first empty slot; last own match wins
		n = 0;
		where = 0;
		stop = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!stop) begin
				if (shadow_table[i] == EMPTY_SLOT) begin
					stop = 1;
				end else begin
					n++;
					if (shadow_table[i] == shadow_own)
						where = i;
				end
			end
		end
		r.cnt = n[CNT_W-1:0];
		r.idx = where[IDX_W-1:0];
		return r;
	endfunction

	function automatic script_row_t mk_row(input bit wr, input logic [1:0] op,
			input logic [ADDR_W-1:0] a, input int rep, input bit fixed,
			input logic [STAT_W-1:0] st, input int cnt, input int idx);
		script_row_t row;
		row.own_wr = wr;
		row.op = op;
		row.addr = a;
		row.rep = rep[4:0];
		row.fixed = fixed;
		row.want.st = st;
		row.want.cnt = cnt[CNT_W-1:0];
		row.want.idx = idx[IDX_W-1:0];
		return row;
	endfunction

	// Idle gap before a word: mostly none or short, now and then long
	function automatic int pick_gap(input bit quiet);
		int k;
		k = $urandom_range(0, 99);
		if (quiet || k < 60)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Addresses mostly from the phase pool, so duplicates and removes hit
	function automatic logic [ADDR_W-1:0] pick_address();
		int k;
		logic [63:0] raw;
		k = $urandom_range(0, 19);
		raw = {$urandom(), $urandom()};
		if (k == 0)
			return '0;
		if (k == 1)
			return EMPTY_SLOT;
		if (k == 2)
			return EMPTY_SLOT - 1;
		if (k <= 5)
			return raw[ADDR_W-1:0];
		return addr_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic [1:0] pick_op();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return OP_INSERT;
		if (k < 94)
			return OP_REMOVE;
		if (k < 97)
			return OP_RESTART;
		return OP_UNUSED;
	endfunction

	// Present one word and hold it until taken; returns its predicted report
	task automatic send_word(input logic [1:0] op, input logic [ADDR_W-1:0] a,
			input int gap, output report_t predicted);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		address <= a;
		do
			@(posedge clk);
		while (busy);
		predicted = table_update(op, a);
		words_sent++;
	endtask

	// Own address is written only once every report is back
	task automatic write_own(input logic [ADDR_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		own_address_we <= 1'b1;
		own_address <= v;
		@(negedge clk);
		own_address_we <= 1'b0;
		shadow_own = v;
		own_writes++;
	endtask

	// Result checker
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && done) begin
			got.st = status;
			got.cnt = entry_count;
			got.idx = own_index;
			status_seen[status]++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected report status %0d count %0d own %0d",
						$realtime, got.st, got.cnt, got.idx);
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: report mismatch, want st %0d cnt %0d own %0d, got st %0d cnt %0d own %0d",
							$realtime, want.st, want.cnt, want.idx, got.st, got.cnt, got.idx);
				end
			end
		end
	end

	initial begin
		report_t pred;
		logic [ADDR_W-1:0] own_pick;
		bit quiet;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_INSERT;
		address = '0;
		own_address_we = 1'b0;
		own_address = '0;
		cycles = 0;
		mismatches = 0;
		reports_checked = 0;
		words_sent = 0;
		own_writes = 0;
		pool_n = 1;
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		for (int i = 0; i < ENTRIES; i++)
			shadow_table[i] = EMPTY_SLOT;
		shadow_own = '0;

		// opening script: empty table, marker value, full table, restarts
		script[0]  = mk_row(1, OP_INSERT, 48'h0, 1, 0, ST_INSERTED, 0, 0);
		script[1]  = mk_row(0, OP_REMOVE, 48'h0, 1, 1, ST_NOT_FOUND, 0, 0);
		script[2]  = mk_row(0, OP_INSERT, EMPTY_SLOT, 1, 1, ST_PRESENT, 0, 0);
		script[3]  = mk_row(0, OP_REMOVE, EMPTY_SLOT, 1, 1, ST_REMOVED, 0, 0);
		script[4]  = mk_row(0, OP_RESTART, 48'h0, 1, 1, ST_RESTARTED, 1, 0);
		script[5]  = mk_row(0, OP_INSERT, 48'h0, 1, 1, ST_PRESENT, 1, 0);
		script[6]  = mk_row(0, OP_UNUSED, 48'hA5A5_5A5A_A5A5, 1, 1, ST_NOT_FOUND, 1, 0);
		script[7]  = mk_row(0, OP_INSERT, 48'hFFFF_FFFF_FFFE, 1, 1, ST_INSERTED, 2, 0);
		script[8]  = mk_row(0, OP_INSERT, 48'h10, 14, 0, ST_INSERTED, 0, 0);
		script[9]  = mk_row(0, OP_INSERT, EMPTY_SLOT, 1, 1, ST_FULL, 16, 0);
		script[10] = mk_row(0, OP_REMOVE, EMPTY_SLOT, 1, 1, ST_NOT_FOUND, 16, 0);
		script[11] = mk_row(0, OP_INSERT, 48'h5, 1, 1, ST_EVICTED, 16, 0);
		script[12] = mk_row(0, OP_INSERT, 48'hFFFF_FFFF_FFFD, 1, 1, ST_FULL, 16, 0);
		script[13] = mk_row(0, OP_REMOVE, 48'h0, 1, 1, ST_REMOVED, 15, 0);
		script[14] = mk_row(1, OP_INSERT, EMPTY_SLOT, 1, 0, ST_INSERTED, 0, 0);
		script[15] = mk_row(0, OP_RESTART, 48'h0, 1, 1, ST_RESTARTED, 0, 0);
		script[16] = mk_row(1, OP_INSERT, 48'h1234_5678_9ABC, 1, 0, ST_INSERTED, 0, 0);
		script[17] = mk_row(0, OP_RESTART, 48'h0, 1, 1, ST_RESTARTED, 1, 0);
		script[18] = mk_row(0, OP_INSERT, 48'h0, 1, 1, ST_INSERTED, 2, 1);
		script[19] = mk_row(0, OP_INSERT, 48'h7FFF_FFFF_FFFF, 1, 0, ST_INSERTED, 0, 0);
		script[20] = mk_row(0, OP_REMOVE, 48'h1234_5678_9ABC, 1, 0, ST_INSERTED, 0, 0);

		// hold reset, then release it on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the script
		for (int r = 0; r < SCRIPT_LEN; r++) begin
			if (script[r].own_wr) begin
				write_own(script[r].addr);
			end else begin
				for (int k = 0; k < script[r].rep; k++) begin
					send_word(script[r].op, script[r].addr + 48'(k * 16), pick_gap(0), pred);
					if (script[r].fixed)
						pending_reports.push_back(script[r].want);
					else
						pending_reports.push_back(pred);
				end
			end
		end

		// random phases: fresh pool and own address, a restart, then mixed traffic
		for (int ph = 0; ph < PHASES; ph++) begin
			pool_n = $urandom_range(6, POOL_MAX);
			for (int i = 0; i < pool_n; i++)
				addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
			case (ph % 4)
				0: own_pick = addr_pool[$urandom_range(0, pool_n - 1)];
				1: own_pick = EMPTY_SLOT;
				2: own_pick = '0;
				default: own_pick = ADDR_W'({$urandom(), $urandom()});
			endcase
			write_own(own_pick);
			quiet = ($urandom_range(0, 2) == 0);
			send_word(OP_RESTART, pick_address(), pick_gap(quiet), pred);
			pending_reports.push_back(pred);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				send_word(pick_op(), pick_address(), pick_gap(quiet), pred);
				pending_reports.push_back(pred);
			end
		end

		// drain
		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d words over %0d own-address settings, %0d reports checked",
			words_sent, own_writes, reports_checked);
		$display("Status mix: ins %0d dup %0d evict %0d full %0d rem %0d miss %0d restart %0d",
			status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_EVICTED],
			status_seen[ST_FULL], status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND],
			status_seen[ST_RESTARTED]);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/sat_pkg.sv
src/sat_ctrl.sv
src/sat_dp.sv
src/sorted_address_table.sv
verif/sorted_address_table_tb.sv
